// File: sv/tsd_pkg.sv
// Shared widths, constants and types of the Taylor sine pipeline.
package tsd_pkg;

  localparam int ANGLE_W     = 17;
  localparam int ANGLE_PAD_W = 24;
  localparam int MAG_W       = 17;
  localparam int HEXP_W      = 4;
  localparam int OUT_W       = 32;

  // Degrees to Q28 radians: xr = MUL_HI*mag + floor((MUL_LO*mag + Y_BIAS) / DIV_K)
  localparam int Y_W         = 26;
  localparam int BASE_W      = 32;
  localparam int YC_W        = 52;
  localparam int Q_W         = 16;
  localparam int RECIP_SHIFT = 36;
  localparam logic [Y_W-1:0]    MUL_LO    = 26'd733;
  localparam logic [Y_W-1:0]    Y_BIAS    = 26'd562;
  localparam logic [Y_W-1:0]    DIV_K     = 26'd1125;
  localparam logic [Y_W-1:0]    REM_LIMIT = 26'd2250;
  localparam logic [BASE_W-1:0] MUL_HI    = 32'd36583;
  // floor(2^36 / 1125)
  localparam logic [Y_W-1:0]    RECIP_C   = 26'd61083979;

  localparam int XR_W   = 32;
  localparam int XSQ_W  = 64;
  localparam int X2_W   = 36;
  localparam int QF     = 28;
  localparam int P_W    = 64;
  localparam int HALF_W = 32;
  localparam int R_W    = 61;
  localparam int TERM_W = 40;
  localparam int SUM_W  = 44;
  localparam int MAX_TERMS = 6;

  // round(2^60 / k!) for k = 1, 3, 5, 7, 9, 11
  localparam logic [R_W-1:0] RECIP_FACT [MAX_TERMS] = '{
    61'd1152921504606846976,
    61'd192153584101141163,
    61'd9607679205057058,
    61'd228754266787073,
    61'd3177142594265,
    61'd28883114493
  };

  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } tsd_ld_t;

endpackage

// File: sv/tsd_step.sv
// One series step: next odd power of x and the matching Taylor term, over two stages.
module tsd_step #(
  parameter int unsigned TermIdx = 0,
  parameter bit          HasPow  = 1'b1
) (
  input  logic                                clk_i,
  input  tsd_pkg::tsd_ld_t                    ld_i,
  input  logic [tsd_pkg::P_W-1:0]             p_i,
  input  logic [tsd_pkg::X2_W-1:0]            x2_i,
  input  logic                                neg_i,
  input  logic signed [tsd_pkg::SUM_W-1:0]    sum_i,
  input  logic [tsd_pkg::TERM_W-1:0]          term_i,
  input  logic                                term_add_i,
  input  logic                                term_sub_i,
  output logic [tsd_pkg::P_W-1:0]             p_o,
  output logic [tsd_pkg::X2_W-1:0]            x2_o,
  output logic                                neg_o,
  output logic signed [tsd_pkg::SUM_W-1:0]    sum_o,
  output logic [tsd_pkg::TERM_W-1:0]          term_o
);

  localparam int HW    = tsd_pkg::HALF_W;
  localparam int RH_W  = tsd_pkg::R_W - HW;
  localparam int PX_W  = HW + tsd_pkg::X2_W;
  localparam int PS_W  = PX_W + HW;
  localparam int TS_W  = 128;
  localparam int TSH   = 72;
  localparam int P_W_HI = tsd_pkg::P_W - 1;
  localparam logic [tsd_pkg::R_W-1:0] Recip = tsd_pkg::RECIP_FACT[TermIdx];
  localparam logic [HW-1:0]   RecipLo = Recip[HW-1:0];
  localparam logic [RH_W-1:0] RecipHi = Recip[tsd_pkg::R_W-1:HW];

  logic signed [tsd_pkg::SUM_W-1:0] term_ext;
  logic signed [tsd_pkg::SUM_W-1:0] sum_a_d, sum_a_q, sum_b_q;
  logic [2*HW-1:0]  tll_q, thl_q;
  logic [HW+RH_W-1:0] tlh_q, thh_q;
  logic             neg_a_q, neg_b_q;
  logic [TS_W-1:0]  tsum;
  logic [tsd_pkg::TERM_W-1:0] term_q;

  // Fold the previous step's term into the running sum
  assign term_ext = signed'({{(tsd_pkg::SUM_W-tsd_pkg::TERM_W){1'b0}}, term_i});

  always_comb begin
    sum_a_d = sum_i;
    if (term_add_i) begin
      if (term_sub_i) begin
        sum_a_d = sum_i - term_ext;
      end else begin
        sum_a_d = sum_i + term_ext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_a) begin
      tll_q   <= (2*HW)'(p_i[HW-1:0])   * (2*HW)'(RecipLo);
      thl_q   <= (2*HW)'(p_i[P_W_HI:HW]) * (2*HW)'(RecipLo);
      tlh_q   <= (HW+RH_W)'(p_i[HW-1:0])   * (HW+RH_W)'(RecipHi);
      thh_q   <= (HW+RH_W)'(p_i[P_W_HI:HW]) * (HW+RH_W)'(RecipHi);
      sum_a_q <= sum_a_d;
      neg_a_q <= neg_i;
    end
  end

  // Round to Q16: add half an LSB at bit 71, keep bits from 72 up
  assign tsum = (TS_W'(thh_q) << (2*HW)) + (TS_W'(tlh_q) << HW) + (TS_W'(thl_q) << HW)
              + TS_W'(tll_q) + (TS_W'(1) << (TSH-1));

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_b) begin
      term_q  <= tsum[TSH +: tsd_pkg::TERM_W];
      sum_b_q <= sum_a_q;
      neg_b_q <= neg_a_q;
    end
  end

  assign term_o = term_q;
  assign sum_o  = sum_b_q;
  assign neg_o  = neg_b_q;

  if (HasPow) begin : g_pow
    logic [PX_W-1:0] plx_q, phx_q;
    logic [PS_W-1:0] psum;
    logic [tsd_pkg::X2_W-1:0] x2_a_q, x2_b_q;
    logic [tsd_pkg::P_W-1:0]  p_q;

    always_ff @(posedge clk_i) begin
      if (ld_i.ld_a) begin
        plx_q  <= PX_W'(p_i[HW-1:0])    * PX_W'(x2_i);
        phx_q  <= PX_W'(p_i[P_W_HI:HW]) * PX_W'(x2_i);
        x2_a_q <= x2_i;
      end
    end

    assign psum = (PS_W'(phx_q) << HW) + PS_W'(plx_q) + (PS_W'(1) << (tsd_pkg::QF-1));

    always_ff @(posedge clk_i) begin
      if (ld_i.ld_b) begin
        p_q    <= psum[tsd_pkg::QF +: tsd_pkg::P_W];
        x2_b_q <= x2_a_q;
      end
    end

    assign p_o  = p_q;
    assign x2_o = x2_b_q;
  end else begin : g_no_pow
    assign p_o  = '0;
    assign x2_o = '0;
  end

endmodule

// File: sv/taylor_sine_degrees.sv
// Top level: pipelined Taylor-series sine of an angle given in degrees.
//
// Input stream: s_axis_tdata carries one angle in degrees, signed Q9.7.
// Output stream: m_axis_tdata carries the partial sine sum, signed Q15.16;
// m_axis_tuser flags a sum that was clipped to the 32-bit range.
// Config channel: cfg_data_i sets the highest odd power in the series
// (reset value 7, values above MAX_EXPONENT act as MAX_EXPONENT, 0 gives 0).
// Write it only while no word is in flight; cfg_ready_o is always high.
//
// Stages: five turn degrees into Q28 radians and x^2, each odd power takes two
// stages (partial products, then the sum), and one stage adds the last term,
// applies the sign and saturates. One word is accepted per cycle while
// s_axis_tready is high.
// Every stage carries a valid bit; a stage loads when it is empty or drains,
// so a stalled receiver fills the bubbles first and s_axis_tready drops only
// once every stage holds a word. Nothing is dropped or repeated on a stall.
// Reset empties the pipeline and restores the exponent register.
module taylor_sine_degrees #(
  parameter int MAX_EXPONENT = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] angle_degrees
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sine_sum
  output logic [0:0]  m_axis_tuser,   // [0] saturated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i      // [3:0] highest_exponent
);

  localparam int NTERMS = (MAX_EXPONENT + 1) / 2;
  localparam int NPRE   = 5;
  localparam int NS     = NPRE + 2*NTERMS + 1;
  localparam logic [tsd_pkg::HEXP_W-1:0] MaxExp = tsd_pkg::HEXP_W'(MAX_EXPONENT);
  localparam int SW = tsd_pkg::SUM_W;

  // ---------------- handshake and valid chain ----------------
  logic [NS-1:0] v_q;
  logic [NS:0]   ld;

  assign ld[NS] = m_axis_tready;
  for (genvar i = 0; i < NS; i++) begin : g_ld
    assign ld[i] = !v_q[i] || ld[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign s_axis_tready = ld[0];
  assign m_axis_tvalid = v_q[NS-1];

  // ---------------- configuration ----------------
  logic [tsd_pkg::HEXP_W-1:0] hexp_q, n_eff;
  logic [NTERMS-1:0]          inc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hexp_q <= 4'd7;
    end else if (cfg_valid_i) begin
      hexp_q <= cfg_data_i;
    end
  end

  assign n_eff = (hexp_q > MaxExp) ? MaxExp : hexp_q;
  for (genvar j = 0; j < NTERMS; j++) begin : g_inc
    assign inc[j] = (tsd_pkg::HEXP_W'(2*j + 1) <= n_eff);
  end

  // ---------------- stage 1: magnitude and split products ----------------
  logic [tsd_pkg::MAG_W-1:0]  mag_d;
  logic                       neg1_q;
  logic [tsd_pkg::Y_W-1:0]    y1_q;
  logic [tsd_pkg::BASE_W-1:0] base1_q;

  assign mag_d = s_axis_tdata[16] ? (~s_axis_tdata[16:0] + 17'd1) : s_axis_tdata[16:0];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      neg1_q  <= s_axis_tdata[16];
      y1_q    <= tsd_pkg::Y_W'(mag_d) * tsd_pkg::MUL_LO + tsd_pkg::Y_BIAS;
      base1_q <= tsd_pkg::BASE_W'(mag_d) * tsd_pkg::MUL_HI;
    end
  end

  // ---------------- stage 2: reciprocal multiply for / 1125 ----------------
  logic                       neg2_q;
  logic [tsd_pkg::Y_W-1:0]    y2_q;
  logic [tsd_pkg::BASE_W-1:0] base2_q;
  logic [tsd_pkg::YC_W-1:0]   yc2_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      neg2_q  <= neg1_q;
      y2_q    <= y1_q;
      base2_q <= base1_q;
      yc2_q   <= tsd_pkg::YC_W'(y1_q) * tsd_pkg::YC_W'(tsd_pkg::RECIP_C);
    end
  end

  // ---------------- stage 3: quotient correction, Q28 radians ----------------
  logic [tsd_pkg::Q_W-1:0]  q0_w, qfix_w;
  logic [tsd_pkg::Y_W-1:0]  rem_w;
  logic                     neg3_q;
  logic [tsd_pkg::XR_W-1:0] xr3_q;

  assign q0_w   = yc2_q[tsd_pkg::RECIP_SHIFT +: tsd_pkg::Q_W];
  assign rem_w  = y2_q - tsd_pkg::Y_W'(q0_w) * tsd_pkg::DIV_K;
  // estimate is low by at most one
  assign qfix_w = q0_w + tsd_pkg::Q_W'(rem_w >= tsd_pkg::DIV_K);

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      neg3_q <= neg2_q;
      xr3_q  <= base2_q + tsd_pkg::XR_W'(qfix_w);
    end
  end

  // ---------------- stage 4: x squared ----------------
  logic                      neg4_q;
  logic [tsd_pkg::XR_W-1:0]  xr4_q;
  logic [tsd_pkg::XSQ_W-1:0] xsq4_q;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      neg4_q <= neg3_q;
      xr4_q  <= xr3_q;
      xsq4_q <= tsd_pkg::XSQ_W'(xr3_q) * tsd_pkg::XSQ_W'(xr3_q);
    end
  end

  // ---------------- stage 5: round x^2 to Q28 ----------------
  logic [tsd_pkg::XSQ_W-1:0] x2sum_w;
  logic                      neg5_q;
  logic [tsd_pkg::XR_W-1:0]  xr5_q;
  logic [tsd_pkg::X2_W-1:0]  x2_5_q;

  assign x2sum_w = xsq4_q + (tsd_pkg::XSQ_W'(1) << (tsd_pkg::QF-1));

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      neg5_q <= neg4_q;
      xr5_q  <= xr4_q;
      x2_5_q <= x2sum_w[tsd_pkg::QF +: tsd_pkg::X2_W];
    end
  end

  // ---------------- series steps ----------------
  logic [tsd_pkg::P_W-1:0]    p_s    [NTERMS];
  logic [tsd_pkg::X2_W-1:0]   x2_s   [NTERMS];
  logic                       neg_s  [NTERMS+1];
  logic signed [SW-1:0]       sum_s  [NTERMS+1];
  logic [tsd_pkg::TERM_W-1:0] term_s [NTERMS+1];
  logic [NTERMS:0]            inc_sh;

  assign p_s[0]    = tsd_pkg::P_W'(xr5_q);
  assign x2_s[0]   = x2_5_q;
  assign neg_s[0]  = neg5_q;
  assign sum_s[0]  = '0;
  assign term_s[0] = '0;
  assign inc_sh    = {inc, 1'b0};

  for (genvar j = 0; j < NTERMS; j++) begin : g_step
    tsd_pkg::tsd_ld_t st_ld;
    assign st_ld.ld_a = ld[NPRE + 2*j];
    assign st_ld.ld_b = ld[NPRE + 2*j + 1];

    if (j < NTERMS - 1) begin : g_mid
      tsd_step #(
        .TermIdx (j),
        .HasPow  (1'b1)
      ) u_step (
        .clk_i      (clk_i),
        .ld_i       (st_ld),
        .p_i        (p_s[j]),
        .x2_i       (x2_s[j]),
        .neg_i      (neg_s[j]),
        .sum_i      (sum_s[j]),
        .term_i     (term_s[j]),
        .term_add_i (inc_sh[j]),
        .term_sub_i ((j % 2) == 0),
        .p_o        (p_s[j+1]),
        .x2_o       (x2_s[j+1]),
        .neg_o      (neg_s[j+1]),
        .sum_o      (sum_s[j+1]),
        .term_o     (term_s[j+1])
      );
    end else begin : g_last
      tsd_step #(
        .TermIdx (j),
        .HasPow  (1'b0)
      ) u_step (
        .clk_i      (clk_i),
        .ld_i       (st_ld),
        .p_i        (p_s[j]),
        .x2_i       (x2_s[j]),
        .neg_i      (neg_s[j]),
        .sum_i      (sum_s[j]),
        .term_i     (term_s[j]),
        .term_add_i (inc_sh[j]),
        .term_sub_i ((j % 2) == 0),
        .p_o        (),
        .x2_o       (),
        .neg_o      (neg_s[j+1]),
        .sum_o      (sum_s[j+1]),
        .term_o     (term_s[j+1])
      );
    end
  end

  // ---------------- output stage: last term, sign, saturate ----------------
  localparam int OUT_LOCAL = tsd_pkg::OUT_W;

  logic signed [SW-1:0] term_last, sum_f, res_w;
  logic                 ovf_w;
  logic [OUT_LOCAL-1:0] out_data_q;
  logic                 out_sat_q;

  assign term_last = signed'({{(SW-tsd_pkg::TERM_W){1'b0}}, term_s[NTERMS]});

  always_comb begin
    sum_f = sum_s[NTERMS];
    if (inc[NTERMS-1]) begin
      if (((NTERMS - 1) % 2) == 1) begin
        sum_f = sum_s[NTERMS] - term_last;
      end else begin
        sum_f = sum_s[NTERMS] + term_last;
      end
    end
    res_w = neg_s[NTERMS] ? -sum_f : sum_f;
    // clip when the bits above the 32-bit sign are not a sign extension
    ovf_w = !((&res_w[SW-1:OUT_LOCAL-1]) || !(|res_w[SW-1:OUT_LOCAL-1]));
  end

  always_ff @(posedge clk_i) begin
    if (ld[NS-1]) begin
      out_sat_q <= ovf_w;
      if (ovf_w) begin
        out_data_q <= res_w[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        out_data_q <= res_w[OUT_LOCAL-1:0];
      end
    end
  end

  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_sat_q;

  // ---------------- assertions ----------------
  // input stalls only with every stage occupied
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&v_q))
    else $error("input stalled while a pipeline stage is empty");

  // reciprocal estimate for / 1125 is off by at most one
  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (rem_w < tsd_pkg::REM_LIMIT))
    else $error("radian conversion remainder out of range");

  // clip flag only with a clipped value
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000))
    else $error("saturation flag set on an unclipped result");

endmodule

// File: dv/tb.sv
// Self-checking stream testbench for the degrees-input Taylor sine pipeline.
`timescale 1ns / 100ps

module tb;

  localparam int EXP_CAP        = 11;
  localparam int PIPE_LATENCY   = 6 + 2 * ((EXP_CAP + 1) / 2);
  localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int NUM_PHASES     = 16;

  // round(2^60 / k!) for k = 1, 3, 5, 7, 9, 11
  localparam logic [63:0] FACT_RECIP_Q60 [6] = '{
    64'd1152921504606846976,
    64'd192153584101141163,
    64'd9607679205057058,
    64'd228754266787073,
    64'd3177142594265,
    64'd28883114493
  };

  localparam logic [3:0] PHASE_EXP [NUM_PHASES] = '{
    4'd11, 4'd0, 4'd15, 4'd1, 4'd12, 4'd3, 4'd5, 4'd2,
    4'd9, 4'd13, 4'd7, 4'd4, 4'd14, 4'd6, 4'd8, 4'd10
  };

  typedef struct packed {
    logic [31:0] sine_sum;
    logic        saturated;
  } sine_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i    = '0;

  logic [16:0]  pending_angles [$];
  sine_result_t expected_sines [$];
  logic [3:0]   exponent_cfg   = 4'd7;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_trigger   = 1'b0;
  bit  ready_hold     = 1'b0;
  bit  in_fire        = 1'b0;
  int  angles_issued   = 0;
  int  angles_accepted = 0;
  int  sines_checked   = 0;
  int  cfg_writes      = 0;
  int  mismatch_count  = 0;
  int  idle_cycles     = 0;

  taylor_sine_degrees u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // (a * b + 2^(s-1)) >> s, low 64 bits kept
  function automatic logic [63:0] round_mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [128:0] prod;
    prod = {65'd0, a} * {65'd0, b};
    prod = prod + (129'd1 << (s - 1));
    return 64'(prod >> s);
  endfunction

  function automatic sine_result_t predict_sine(logic [16:0] angle, logic [3:0] hexp);
    logic               neg;
    logic [63:0]        mag;
    logic [127:0]       scaled;
    logic [63:0]        xr;
    logic [63:0]        x2;
    logic [63:0]        pw;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic signed [63:0] res;
    int                 n;
    sine_result_t       r;
    neg = angle[16];
    mag = neg ? 64'(18'h20000 - {1'b0, angle}) : 64'(angle);
    n = (int'(hexp) > EXP_CAP) ? EXP_CAP : int'(hexp);
    // degrees to Q28 radians with the 3.14/180 factor, rounded half up
    scaled = 128'(mag) * 128'd314 * (128'd1 << 28) + 128'd1152000;
    xr = 64'(scaled / 128'd2304000);
    x2 = round_mul_shift(xr, xr, 28);
    pw = xr;
    acc = '0;
    for (int j = 0; j < 6 && 2 * j + 1 <= n; j++) begin
      if (j > 0) pw = round_mul_shift(pw, x2, 28);
      term = round_mul_shift(pw, FACT_RECIP_Q60[j], 72);
      if (j % 2 == 1) acc = acc - $signed(term);
      else            acc = acc + $signed(term);
    end
    res = neg ? -acc : acc;
    r.saturated = 1'b0;
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      r.saturated = 1'b1;
    end else if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.sine_sum = res[31:0];
    return r;
  endfunction

  function automatic logic [16:0] random_angle();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      v = int'($urandom_range(0, 92160)) - 46080;
    end else if (sel < 9) begin
      v = int'($urandom);
    end else begin
      v = int'($urandom_range(0, 64)) - 32;
    end
    return 17'(v);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %08h, want %08h (result %0d)", what, got, want, sines_checked);
    mismatch_count++;
  endtask

  task automatic queue_angle(logic [16:0] angle);
    pending_angles.push_back(angle);
    angles_issued++;
  endtask

  // Wait until every issued word has come back, then let the pipe settle.
  task automatic drain_pipe();
    while (angles_accepted != angles_issued || expected_sines.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_exponent(logic [3:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    exponent_cfg = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Driver: hold the word until taken, then offer the next or idle.
  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && !in_fire)) begin
      if (pending_angles.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata  <= {7'd0, pending_angles.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !ready_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Long receiver hold-off so the pipe fills and backs up the input.
  initial begin
    wait (hold_trigger);
    ready_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    ready_hold = 1'b0;
  end

  // Monitor: predict on input words, check output words in order.
  always @(posedge clk_i) begin
    sine_result_t want;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_sines.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 32'd0);
      end else begin
        want = expected_sines.pop_front();
        if (m_axis_tdata !== want.sine_sum)
          report_mismatch("sine_sum", m_axis_tdata, want.sine_sum);
        if (m_axis_tuser[0] !== want.saturated)
          report_mismatch("saturated", {31'd0, m_axis_tuser[0]}, {31'd0, want.saturated});
      end
      sines_checked++;
    end
    if (in_fire) begin
      expected_sines.push_back(predict_sine(s_axis_tdata[16:0], exponent_cfg));
      angles_accepted++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed angles at the reset exponent: extremes, quadrants, beyond 360
    queue_angle(17'sd0);
    queue_angle(17'sd1);
    queue_angle(-17'sd1);
    queue_angle(17'sd2);
    queue_angle(17'sd128);
    queue_angle(-17'sd128);
    queue_angle(17'sd11520);
    queue_angle(-17'sd11520);
    queue_angle(17'sd23040);
    queue_angle(-17'sd23040);
    queue_angle(17'sd34560);
    queue_angle(17'sd46080);
    queue_angle(-17'sd46080);
    queue_angle(17'h0FFFF);
    queue_angle(17'h10000);
    queue_angle(17'h10001);
    queue_angle(17'h15555);
    queue_angle(17'h0AAAA);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipe();
      write_exponent(PHASE_EXP[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (p == 0) hold_trigger = 1'b1;
      for (int i = 0; i < ((p == 0) ? 150 : 70); i++) queue_angle(random_angle());
    end
    drain_pipe();

    $display("Checked %0d sine results over %0d exponent settings, %0d mismatches.",
             sines_checked, cfg_writes + 1, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
